[design/clr_pkg.sv]
// Shared constants for the clipped line and rectangle rasterizer.
`default_nettype none

package clr_pkg;

  localparam int DEF_MAX_DIM    = 4096;
  localparam int DEF_COORD_BITS = 14;

  localparam int OP_BITS     = 2;
  localparam int COLOR_BITS  = 32;
  localparam int ADDR_BITS   = 24;
  localparam int CANVAS_BITS = 13;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam logic [OP_BITS-1:0] OP_LOAD_LINE = 2'd0;
  localparam logic [OP_BITS-1:0] OP_LOAD_RECT = 2'd1;
  localparam logic [OP_BITS-1:0] OP_STEP      = 2'd2;

  localparam logic [0:0] REG_CANVAS_WIDTH  = 1'b0;
  localparam logic [0:0] REG_CANVAS_HEIGHT = 1'b1;

  localparam logic [CANVAS_BITS-1:0] CANVAS_WIDTH_RESET  = 13'd1024;
  localparam logic [CANVAS_BITS-1:0] CANVAS_HEIGHT_RESET = 13'd768;

  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_RIGHT  = 2'd1;
  localparam logic [1:0] EDGE_BOTTOM = 2'd2;
  localparam logic [1:0] EDGE_LEFT   = 2'd3;

endpackage

`default_nettype wire

[design/clipped_line_rectangle_rasterizer.sv]
// Line and rectangle outline Bresenham rasterizer with canvas clip and addressing.
// Throughput: one input transaction per cycle while the output is not stalled; each
// step is one Bresenham update done in the cycle of acceptance, and the clip and
// address multiply follow in a second register stage. Reset returns the rasterizer
// to idle, empties both pipeline stages and sets the canvas to 1024 by 768.
`default_nettype none

module clipped_line_rectangle_rasterizer
  import clr_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // from_x, from_y, to_x, to_y, pixel_color from the lowest bit up.
  input  wire logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_tdata,
  // opcode.
  input  wire logic [OP_BITS-1:0]           s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // out_x, out_y, pixel_address, out_color from the lowest bit up.
  output logic [((2*COORD_BITS+ADDR_BITS+COLOR_BITS+7)/8)*8-1:0] m_tdata,
  // write_enable.
  output logic                              m_tuser,
  output logic                              m_tlast,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [APB_ADDR_BITS-1:0]     paddr,
  input  wire logic [APB_DATA_BITS-1:0]     pwdata,
  output logic [APB_DATA_BITS-1:0]          prdata,
  output logic                              pready
);

  localparam int CB      = COORD_BITS;
  localparam int OUT_W   = ((2*CB + ADDR_BITS + COLOR_BITS + 7) / 8) * 8;
  localparam int DIM_W   = $clog2(MAX_DIM + 1) > CANVAS_BITS ?
                           $clog2(MAX_DIM + 1) : CANVAS_BITS;
  localparam int CMP_W   = CB > CANVAS_BITS ? CB : CANVAS_BITS;
  localparam int MUL_W   = CB - 1 + CANVAS_BITS;
  localparam int SUM_W   = MUL_W + 1;
  localparam int ERR_W   = CB + 4;

  // Configuration registers.
  logic [CANVAS_BITS-1:0] canvas_width;
  logic [CANVAS_BITS-1:0] canvas_height;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CANVAS_WIDTH_RESET;
      canvas_height <= CANVAS_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2:2])
        REG_CANVAS_WIDTH:  canvas_width  <= pwdata[CANVAS_BITS-1:0];
        REG_CANVAS_HEIGHT: canvas_height <= pwdata[CANVAS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      REG_CANVAS_WIDTH:  prdata = APB_DATA_BITS'(canvas_width);
      REG_CANVAS_HEIGHT: prdata = APB_DATA_BITS'(canvas_height);
      default:           prdata = '0;
    endcase
  end

  // Input fields.
  logic signed [CB-1:0]   in_from_x, in_from_y, in_to_x, in_to_y;
  logic [COLOR_BITS-1:0]  in_color;

  assign in_from_x = s_tdata[CB-1:0];
  assign in_from_y = s_tdata[2*CB-1:CB];
  assign in_to_x   = s_tdata[3*CB-1:2*CB];
  assign in_to_y   = s_tdata[4*CB-1:3*CB];
  assign in_color  = s_tdata[4*CB +: COLOR_BITS];

  // Shape state.
  logic signed [CB-1:0]  pos_x, pos_y, target_x, target_y;
  logic [CB:0]           span_x;
  logic signed [CB+1:0]  neg_span_y;
  logic                  dir_x_negative, dir_y_negative;
  logic signed [ERR_W-1:0] error_term;
  logic [COLOR_BITS-1:0] shape_color_reg;
  logic                  busy, outline_mode;
  logic [1:0]            edge_index;
  logic signed [CB-1:0]  rect_corners [4];

  logic signed [CB-1:0]  pos_x_next, pos_y_next, target_x_next, target_y_next;
  logic [CB:0]           span_x_next;
  logic signed [CB+1:0]  neg_span_y_next;
  logic                  dir_x_negative_next, dir_y_negative_next;
  logic signed [ERR_W-1:0] error_term_next;
  logic                  busy_next, outline_mode_next;
  logic [1:0]            edge_index_next;

  logic accept, is_line, is_rect, is_step, produce, at_end, do_setup;
  logic at_end_next, final_pixel;
  logic [1:0] edge_inc;
  logic signed [CB-1:0] x0, y0, x1, y1;
  logic signed [CB:0]   dx, dy;
  logic [CB:0]          abs_dy;
  logic signed [ERR_W:0] twice;

  assign accept  = s_tvalid && s_tready;
  assign is_line = (s_tuser == OP_LOAD_LINE);
  assign is_rect = (s_tuser == OP_LOAD_RECT);
  assign is_step = (s_tuser == OP_STEP) && busy;
  assign produce = is_line || is_rect || is_step;
  assign at_end  = (pos_x == target_x) && (pos_y == target_y);
  assign do_setup = is_line || is_rect || (is_step && at_end);
  assign edge_inc = edge_index + 2'd1;

  // Endpoints of the line that starts now.
  always_comb begin
    if (is_line) begin
      x0 = in_from_x; y0 = in_from_y; x1 = in_to_x; y1 = in_to_y;
    end else if (is_rect) begin
      x0 = in_from_x; y0 = in_from_y; x1 = in_to_x; y1 = in_from_y;
    end else begin
      case (edge_inc)
        EDGE_RIGHT: begin
          x0 = rect_corners[2]; y0 = rect_corners[1];
          x1 = rect_corners[2]; y1 = rect_corners[3];
        end
        EDGE_BOTTOM: begin
          x0 = rect_corners[2]; y0 = rect_corners[3];
          x1 = rect_corners[0]; y1 = rect_corners[3];
        end
        EDGE_LEFT: begin
          x0 = rect_corners[0]; y0 = rect_corners[3];
          x1 = rect_corners[0]; y1 = rect_corners[1];
        end
        default: begin
          x0 = rect_corners[0]; y0 = rect_corners[1];
          x1 = rect_corners[2]; y1 = rect_corners[1];
        end
      endcase
    end
  end

  assign dx     = (CB+1)'(x1) - (CB+1)'(x0);
  assign dy     = (CB+1)'(y1) - (CB+1)'(y0);
  assign abs_dy = dy[CB] ? (CB+1)'(-dy) : (CB+1)'(dy);
  assign twice  = $signed({error_term, 1'b0});

  always_comb begin
    pos_x_next          = pos_x;
    pos_y_next          = pos_y;
    target_x_next       = target_x;
    target_y_next       = target_y;
    span_x_next         = span_x;
    neg_span_y_next     = neg_span_y;
    dir_x_negative_next = dir_x_negative;
    dir_y_negative_next = dir_y_negative;
    error_term_next     = error_term;
    outline_mode_next   = outline_mode;
    edge_index_next     = edge_index;
    if (do_setup) begin
      pos_x_next          = x0;
      pos_y_next          = y0;
      target_x_next       = x1;
      target_y_next       = y1;
      span_x_next         = dx[CB] ? (CB+1)'(-dx) : (CB+1)'(dx);
      neg_span_y_next     = -$signed({1'b0, abs_dy});
      dir_x_negative_next = !(x0 < x1);
      dir_y_negative_next = !(y0 < y1);
      error_term_next     = ERR_W'($signed({1'b0, span_x_next})) +
                            ERR_W'(neg_span_y_next);
    end else if (is_step) begin
      if (twice >= (ERR_W+1)'(neg_span_y)) begin
        error_term_next = error_term_next + ERR_W'(neg_span_y);
        pos_x_next      = dir_x_negative ? pos_x - 1'b1 : pos_x + 1'b1;
      end
      if (twice <= (ERR_W+1)'($signed({1'b0, span_x}))) begin
        error_term_next = error_term_next + ERR_W'($signed({1'b0, span_x}));
        pos_y_next      = dir_y_negative ? pos_y - 1'b1 : pos_y + 1'b1;
      end
    end
    if (is_line) begin
      outline_mode_next = 1'b0;
      edge_index_next   = EDGE_TOP;
    end else if (is_rect) begin
      outline_mode_next = 1'b1;
      edge_index_next   = EDGE_TOP;
    end else if (is_step && at_end) begin
      edge_index_next   = edge_inc;
    end
  end

  assign at_end_next = (pos_x_next == target_x_next) && (pos_y_next == target_y_next);
  assign final_pixel = at_end_next && !(outline_mode_next && (edge_index_next != EDGE_LEFT));
  assign busy_next   = produce ? !final_pixel : busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      outline_mode <= 1'b0;
      edge_index   <= EDGE_TOP;
    end else if (accept) begin
      busy         <= busy_next;
      outline_mode <= outline_mode_next;
      edge_index   <= edge_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_x          <= pos_x_next;
      pos_y          <= pos_y_next;
      target_x       <= target_x_next;
      target_y       <= target_y_next;
      span_x         <= span_x_next;
      neg_span_y     <= neg_span_y_next;
      dir_x_negative <= dir_x_negative_next;
      dir_y_negative <= dir_y_negative_next;
      error_term     <= error_term_next;
      if (is_line || is_rect) begin
        shape_color_reg <= in_color;
      end
      if (is_rect) begin
        rect_corners[0] <= in_from_x;
        rect_corners[1] <= in_from_y;
        rect_corners[2] <= in_to_x;
        rect_corners[3] <= in_to_y;
      end
    end
  end

  // First pixel stage.
  logic                  s1_valid, s1_advance, s1_last;
  logic signed [CB-1:0]  s1_x, s1_y;
  logic [COLOR_BITS-1:0] s1_color;

  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= produce;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x     <= pos_x_next;
      s1_y     <= pos_y_next;
      s1_last  <= final_pixel;
      s1_color <= (is_line || is_rect) ? in_color : shape_color_reg;
    end
  end

  // Clip and address.
  logic                 dims_ok, in_canvas;
  logic [MUL_W-1:0]     row_base;
  logic [SUM_W-1:0]     lin_addr;
  logic [ADDR_BITS-1:0] addr_out;

  assign dims_ok = (canvas_width != '0) && (DIM_W'(canvas_width) <= DIM_W'(MAX_DIM)) &&
                   (canvas_height != '0) && (DIM_W'(canvas_height) <= DIM_W'(MAX_DIM));
  assign in_canvas = dims_ok && !s1_x[CB-1] && !s1_y[CB-1] &&
                     (CMP_W'(unsigned'(s1_x)) < CMP_W'(canvas_width)) &&
                     (CMP_W'(unsigned'(s1_y)) < CMP_W'(canvas_height));
  assign row_base = MUL_W'(s1_y[CB-2:0]) * MUL_W'(canvas_width);
  assign lin_addr = SUM_W'(row_base) + SUM_W'(s1_x[CB-2:0]);
  assign addr_out = in_canvas ? ADDR_BITS'(lin_addr) : '0;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_tdata <= OUT_W'({s1_color, addr_out, s1_y, s1_x});
      m_tuser <= in_canvas;
      m_tlast <= s1_last;
    end
  end

endmodule

`default_nettype wire

[test/tb_clipped_line_rectangle_rasterizer.sv]
// Self-checking testbench for the clipped line and rectangle outline rasterizer.
`default_nettype none

module tb_clipped_line_rectangle_rasterizer;
  import clr_pkg::*;

  localparam int CB = DEF_COORD_BITS;
  localparam int S_BITS = ((4*CB+COLOR_BITS+7)/8)*8;
  localparam int M_BITS = ((2*CB+ADDR_BITS+COLOR_BITS+7)/8)*8;
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 130;

  typedef struct packed {
    bit [CB-1:0] x;
    bit [CB-1:0] y;
    bit we;
    bit [ADDR_BITS-1:0] addr;
    bit [COLOR_BITS-1:0] color;
    bit last;
  } pixel_t;

  typedef struct packed {
    bit fixed;
    pixel_t px;
  } pending_t;

  typedef struct packed {
    bit [OP_BITS-1:0] op;
    int fx;
    int fy;
    int tx;
    int ty;
    bit [COLOR_BITS-1:0] color;
    bit fixed;
    int ex;
    int ey;
    bit we;
    int addr;
    bit last;
  } row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_BITS-1:0] s_tdata;
  logic [OP_BITS-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [M_BITS-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  clipped_line_rectangle_rasterizer dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  int canvas_w;
  int canvas_h;
  int pen_x;
  int pen_y;
  int goal_x;
  int goal_y;
  int run_x;
  int neg_run_y;
  int err_acc;
  bit step_x_back;
  bit step_y_back;
  bit [COLOR_BITS-1:0] ink;
  bit drawing;
  bit outline;
  bit [1:0] side;
  int corner [4];

  pixel_t pending_pixels [$];
  pending_t load_tags [$];
  row_t script [$];
  int errors;
  int cycles;
  bit gaps_on;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int span_of(input int a, input int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic int clamp_coord(input int v);
    return v < -8192 ? -8192 : (v > 8191 ? 8191 : v);
  endfunction

  function automatic void start_segment(input int x0, input int y0, input int x1, input int y1);
    pen_x = x0;
    pen_y = y0;
    goal_x = x1;
    goal_y = y1;
    run_x = span_of(x0, x1);
    neg_run_y = -span_of(y0, y1);
    step_x_back = !(x0 < x1);
    step_y_back = !(y0 < y1);
    err_acc = run_x + neg_run_y;
  endfunction

  function automatic void start_side(input bit [1:0] k);
    case (k)
      EDGE_TOP: start_segment(corner[0], corner[1], corner[2], corner[1]);
      EDGE_RIGHT: start_segment(corner[2], corner[1], corner[2], corner[3]);
      EDGE_BOTTOM: start_segment(corner[2], corner[3], corner[0], corner[3]);
      default: start_segment(corner[0], corner[3], corner[0], corner[1]);
    endcase
  endfunction

  function automatic pixel_t plot_pixel();
    pixel_t px;
    bit dims_ok;
    bit in_canvas;
    bit at_goal;
    dims_ok = canvas_w >= 1 && canvas_w <= DEF_MAX_DIM && canvas_h >= 1 &&
              canvas_h <= DEF_MAX_DIM;
    in_canvas = dims_ok && pen_x >= 0 && pen_y >= 0 && pen_x < canvas_w && pen_y < canvas_h;
    at_goal = pen_x == goal_x && pen_y == goal_y;
    px.last = at_goal && !(outline && side != EDGE_LEFT);
    drawing = !px.last;
    px.x = CB'(pen_x);
    px.y = CB'(pen_y);
    px.we = in_canvas;
    px.addr = in_canvas ? ADDR_BITS'(pen_y * canvas_w + pen_x) : '0;
    px.color = ink;
    return px;
  endfunction

  function automatic bit rasterize(input bit [OP_BITS-1:0] op, input int fx, input int fy,
                                   input int tx, input int ty, input bit [COLOR_BITS-1:0] color,
                                   output pixel_t px);
    int twice;
    px = '0;
    if (op == OP_LOAD_LINE || op == OP_LOAD_RECT) begin
      ink = color;
      outline = op == OP_LOAD_RECT;
      side = EDGE_TOP;
      if (outline) begin
        corner[0] = fx;
        corner[1] = fy;
        corner[2] = tx;
        corner[3] = ty;
        start_side(EDGE_TOP);
      end else begin
        start_segment(fx, fy, tx, ty);
      end
    end else if (op == OP_STEP && drawing) begin
      if (pen_x == goal_x && pen_y == goal_y) begin
        side = side + 2'd1;
        start_side(side);
      end else begin
        twice = err_acc * 2;
        if (twice >= neg_run_y) begin
          err_acc += neg_run_y;
          pen_x += step_x_back ? -1 : 1;
        end
        if (twice <= run_x) begin
          err_acc += run_x;
          pen_y += step_y_back ? -1 : 1;
        end
      end
    end else begin
      return 1'b0;
    end
    px = plot_pixel();
    return 1'b1;
  endfunction

  always @(posedge clk) begin : monitor
    pixel_t got;
    pixel_t want;
    pixel_t fresh;
    pending_t tag;
    if (m_tvalid && m_tready) begin
      got.x = m_tdata[CB-1:0];
      got.y = m_tdata[2*CB-1:CB];
      got.addr = m_tdata[2*CB+ADDR_BITS-1:2*CB];
      got.color = m_tdata[2*CB+ADDR_BITS+COLOR_BITS-1:2*CB+ADDR_BITS];
      got.we = m_tuser;
      got.last = m_tlast;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel transaction x=%0d y=%0d", $signed(got.x), $signed(got.y));
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.x !== want.x) begin
          $error("out_x expected %0d got %0d", $signed(want.x), $signed(got.x));
          errors++;
        end
        if (got.y !== want.y) begin
          $error("out_y expected %0d got %0d", $signed(want.y), $signed(got.y));
          errors++;
        end
        if (got.we !== want.we) begin
          $error("write_enable expected %0d got %0d", want.we, got.we);
          errors++;
        end
        if (got.addr !== want.addr) begin
          $error("pixel_address expected %0d got %0d", want.addr, got.addr);
          errors++;
        end
        if (got.color !== want.color) begin
          $error("out_color expected %h got %h", want.color, got.color);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last_pixel expected %0d got %0d", want.last, got.last);
          errors++;
        end
      end
    end
    if (s_tvalid && s_tready) begin
      tag = load_tags.size() != 0 ? load_tags.pop_front() : pending_t'(0);
      if (rasterize(s_tuser, int'($signed(s_tdata[CB-1:0])), int'($signed(s_tdata[2*CB-1:CB])),
                    int'($signed(s_tdata[3*CB-1:2*CB])), int'($signed(s_tdata[4*CB-1:3*CB])),
                    s_tdata[4*CB+COLOR_BITS-1:4*CB], fresh)) begin
        pending_pixels.push_back(tag.fixed ? tag.px : fresh);
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= !gaps_on || ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input bit [OP_BITS-1:0] op, input int fx, input int fy, input int tx,
                           input int ty, input bit [COLOR_BITS-1:0] color, input pending_t tag);
    while (gaps_on && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {color, CB'(ty), CB'(tx), CB'(fy), CB'(fx)};
    load_tags.push_back(tag);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes one canvas register and reads it back in the following transaction.
  task automatic set_reg(input logic [0:0] idx, input bit [CANVAS_BITS-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {(APB_DATA_BITS-CANVAS_BITS)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_CANVAS_WIDTH) begin
      canvas_w = value;
    end else begin
      canvas_h = value;
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== APB_DATA_BITS'(value)) begin
      $error("register %0d readback expected %0d got %0d", idx, value, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int pick_coord(input int dim);
    int lim;
    lim = (dim >= 1 && dim <= DEF_MAX_DIM) ? dim : 64;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'($urandom_range(0, 16)) - 8;
      4, 5, 6: return lim + int'($urandom_range(0, 16)) - 8;
      7, 8: return int'($urandom_range(0, lim - 1));
      default: return int'($urandom_range(0, 16383)) - 8192;
    endcase
  endfunction

  task automatic run_phase(input int quota);
    int sent;
    int fx;
    int fy;
    int tx;
    int ty;
    int reach;
    int pixels;
    int steps;
    bit far;
    bit [OP_BITS-1:0] op;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 19) == 0) begin
        op = $urandom_range(0, 1) ? OP_STEP : OP_UNUSED;
        send_item(op, $urandom, $urandom, $urandom, $urandom, $urandom, '0);
        continue;
      end
      op = $urandom_range(0, 1) ? OP_LOAD_RECT : OP_LOAD_LINE;
      far = $urandom_range(0, 11) == 0;
      fx = pick_coord(canvas_w);
      fy = pick_coord(canvas_h);
      if (far) begin
        tx = int'($urandom_range(0, 16383)) - 8192;
        ty = int'($urandom_range(0, 16383)) - 8192;
      end else begin
        reach = $urandom_range(0, 4) == 0 ? 40 : 6;
        tx = clamp_coord(fx + int'($urandom_range(0, 2 * reach)) - reach);
        ty = clamp_coord(fy + int'($urandom_range(0, 2 * reach)) - reach);
      end
      if (op == OP_LOAD_RECT) begin
        pixels = 2 * (span_of(fx, tx) + span_of(fy, ty)) + 4;
      end else begin
        pixels = span_of(fx, tx) > span_of(fy, ty) ? span_of(fx, tx) : span_of(fy, ty);
        pixels = pixels + 1;
      end
      if (pixels > 400) begin
        steps = $urandom_range(0, 24);
      end else begin
        case ($urandom_range(0, 9))
          0: steps = $urandom_range(0, pixels - 1);
          1: steps = pixels - 1 + int'($urandom_range(1, 3));
          default: steps = pixels - 1;
        endcase
      end
      send_item(op, fx, fy, tx, ty, $urandom, '0);
      repeat (steps) send_item(OP_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, '0);
      sent += 1 + (steps < pixels ? steps : pixels - 1);
    end
  endtask

  initial begin
    int phase_w [8];
    int phase_h [8];
    pending_t tag;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_STEP;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    cycles = 0;
    gaps_on = 1'b1;
    canvas_w = CANVAS_WIDTH_RESET;
    canvas_h = CANVAS_HEIGHT_RESET;
    pen_x = 0;
    pen_y = 0;
    goal_x = 0;
    goal_y = 0;
    run_x = 0;
    neg_run_y = 0;
    err_acc = 0;
    step_x_back = 1'b0;
    step_y_back = 1'b0;
    ink = '0;
    drawing = 1'b0;
    outline = 1'b0;
    side = EDGE_TOP;
    corner = '{0, 0, 0, 0};
    phase_w = '{1, 4096, 0, 640, 4097, 8191, 0, 0};
    phase_h = '{1, 4096, 300, 8191, 4096, 0, 0, 0};
    phase_w[6] = $urandom_range(1, 4096);
    phase_h[6] = $urandom_range(1, 4096);
    phase_w[7] = $urandom_range(1, 4096);
    phase_h[7] = $urandom_range(1, 4096);

    script = '{
      '{OP_STEP, 5, -5, 100, -100, 32'hDEAD_BEEF, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_UNUSED, 1, 2, 3, 4, 32'h1234_5678, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_LOAD_LINE, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b1, 0, 0, 1'b1, 0, 1'b1},
      '{OP_LOAD_LINE, 1023, 767, 1023, 767, 32'h0, 1'b1, 1023, 767, 1'b1, 786431, 1'b1},
      '{OP_LOAD_LINE, 1024, 0, 1024, 0, 32'h1, 1'b1, 1024, 0, 1'b0, 0, 1'b1},
      '{OP_LOAD_LINE, 0, -1, 0, -1, 32'h8000_0000, 1'b1, 0, -1, 1'b0, 0, 1'b1},
      '{OP_LOAD_LINE, -8192, 8191, 8191, -8192, 32'h0F0F_0F0F, 1'b1, -8192, 8191, 1'b0, 0,
        1'b0},
      '{OP_STEP, 0, 0, 0, 0, 32'h0, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_LOAD_RECT, 1022, 766, 1024, 768, 32'h5A5A_5A5A, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_STEP, -1, -1, -1, -1, 32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, 32'h0, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, 32'h0, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, 32'h0, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, 32'h0, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, 32'h0, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, 32'h0, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, 32'h0, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, 32'h0, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, 32'h0, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, 32'h0, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_STEP, 0, 0, 0, 0, 32'h0, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_UNUSED, -8192, 8191, -8192, 8191, 32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0, 0, 1'b0},
      '{OP_LOAD_LINE, 8191, -8192, 8191, -8192, 32'hF0F0_F0F0, 1'b1, 8191, -8192, 1'b0, 0,
        1'b1}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      tag.fixed = script[i].fixed;
      tag.px.x = CB'(script[i].ex);
      tag.px.y = CB'(script[i].ey);
      tag.px.we = script[i].we;
      tag.px.addr = ADDR_BITS'(script[i].addr);
      tag.px.color = script[i].color;
      tag.px.last = script[i].last;
      send_item(script[i].op, script[i].fx, script[i].fy, script[i].tx, script[i].ty,
                script[i].color, tag);
    end
    run_phase(PHASE_ITEMS);
    drain();

    for (int p = 0; p < 8; p++) begin
      set_reg(REG_CANVAS_WIDTH, CANVAS_BITS'(phase_w[p]));
      set_reg(REG_CANVAS_HEIGHT, CANVAS_BITS'(phase_h[p]));
      gaps_on = p != 1;
      run_phase(PHASE_ITEMS);
      drain();
      gaps_on = 1'b1;
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
